// ===== rtl/usp_pkg.sv =====
// Shared constants, types and the tracker-name table of the URL parameter stripper.
package usp_pkg;

    // Scan modes of the URL tracker.
    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_PATH  = 3'd1;
    localparam logic [2:0] MODE_KEY   = 3'd2;
    localparam logic [2:0] MODE_VALUE = 3'd3;
    localparam logic [2:0] MODE_FRAG  = 3'd4;

    // Depth of the key hold buffer and size of the built-in tracker table.
    localparam int HOLD_DEPTH = 8;
    localparam int TRK_TABLE  = 16;

    // ASCII code units used by the scanner.
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_LC_H  = 8'h68;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_P  = 8'h70;
    localparam logic [7:0] CH_LC_S  = 8'h73;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;

    // Flags that travel with every output beat.
    typedef struct packed {
        logic char_valid;
        logic run_last;
        logic text_done;
        logic text_changed;
    } beat_flags_t;

    // Tracker names, right aligned: the last character sits in the low byte.
    function automatic logic [63:0] trk_word(input logic [3:0] idx);
        logic [63:0] w;
        unique case (idx)
            4'd0:    w = 64'("utm_");
            4'd1:    w = 64'("fbclid");
            4'd2:    w = 64'("gclid");
            4'd3:    w = 64'("gclsrc");
            4'd4:    w = 64'("dclid");
            4'd5:    w = 64'("msclkid");
            4'd6:    w = 64'("si");
            4'd7:    w = 64'("igshid");
            4'd8:    w = 64'("mc_eid");
            4'd9:    w = 64'("mc_cid");
            4'd10:   w = 64'("_hsenc");
            4'd11:   w = 64'("_hsmi");
            4'd12:   w = 64'("ref_src");
            4'd13:   w = 64'("ref_url");
            4'd14:   w = 64'("spm");
            default: w = 64'("vero_id");
        endcase
        return w;
    endfunction

    function automatic logic [3:0] trk_len(input logic [3:0] idx);
        logic [3:0] n;
        unique case (idx)
            4'd0:    n = 4'd4;
            4'd1:    n = 4'd6;
            4'd2:    n = 4'd5;
            4'd3:    n = 4'd6;
            4'd4:    n = 4'd5;
            4'd5:    n = 4'd7;
            4'd6:    n = 4'd2;
            4'd7:    n = 4'd6;
            4'd8:    n = 4'd6;
            4'd9:    n = 4'd6;
            4'd10:   n = 4'd6;
            4'd11:   n = 4'd5;
            4'd12:   n = 4'd7;
            4'd13:   n = 4'd7;
            4'd14:   n = 4'd3;
            default: n = 4'd7;
        endcase
        return n;
    endfunction

    // Character number pos (from the start) of tracker idx; zero past its end.
    function automatic logic [7:0] trk_char(input logic [3:0] idx, input logic [2:0] pos);
        logic [63:0] w;
        logic [3:0]  n;
        logic [2:0]  sh;
        w  = trk_word(idx);
        n  = trk_len(idx);
        sh = 3'(n - 4'd1 - {1'b0, pos});
        if ({1'b0, pos} >= n)
            return 8'h00;
        return w[{sh, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/usp_fifo.sv =====
// Small first-word-fall-through queue built from registers.
module usp_fifo #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]      slot_reg [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_ptr_reg, wr_ptr_next;
    logic [DEPTH_LOG2-1:0] rd_ptr_reg, rd_ptr_next;
    logic [DEPTH_LOG2:0]   count_reg, count_next;
    logic                  do_wr, do_rd;

    assign full    = (count_reg == (DEPTH_LOG2+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    // Occupancy can never pass the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (DEPTH_LOG2+1)'(DEPTH))
        else $error("queue occupancy above depth");

endmodule

// ===== rtl/usp_front.sv =====
// Front part: scans each character, tracks URL state and emits at most one expansion command per item.
module usp_front #(
    parameter int CHAR_BITS     = 16,
    parameter int TRACKER_COUNT = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [CHAR_BITS-1:0]          in_char,
    input  logic                          char_present,
    input  logic                          text_end,
    input  logic                          cmd_full,
    output logic                          cmd_push,
    output logic [9*CHAR_BITS+8:0]        cmd_data
);

    localparam int CW   = CHAR_BITS;
    localparam int HD   = usp_pkg::HOLD_DEPTH;
    localparam int NTRK = (TRACKER_COUNT < usp_pkg::TRK_TABLE) ?
                          TRACKER_COUNT : usp_pkg::TRK_TABLE;

    localparam logic [CW-1:0] C_QUEST = CW'(usp_pkg::CH_QUEST);
    localparam logic [CW-1:0] C_HASH  = CW'(usp_pkg::CH_HASH);
    localparam logic [CW-1:0] C_AMP   = CW'(usp_pkg::CH_AMP);
    localparam logic [CW-1:0] C_EQ    = CW'(usp_pkg::CH_EQ);
    localparam logic [CW-1:0] C_H     = CW'(usp_pkg::CH_LC_H);
    localparam logic [CW-1:0] C_T     = CW'(usp_pkg::CH_LC_T);
    localparam logic [CW-1:0] C_P     = CW'(usp_pkg::CH_LC_P);
    localparam logic [CW-1:0] C_S     = CW'(usp_pkg::CH_LC_S);
    localparam logic [CW-1:0] C_COLON = CW'(usp_pkg::CH_COLON);
    localparam logic [CW-1:0] C_SLASH = CW'(usp_pkg::CH_SLASH);
    localparam logic [CW-1:0] C_UNDER = CW'(usp_pkg::CH_UNDER);
    localparam logic [CW-1:0] C_UC_A  = CW'(usp_pkg::CH_UC_A);
    localparam logic [CW-1:0] C_UC_Z  = CW'(usp_pkg::CH_UC_Z);

    logic            accept;
    logic [2:0]      mode_reg, mode_next;
    logic [3:0]      spos_reg, spos_next;
    logic [3:0]      hcnt_reg, hcnt_next;
    logic [NTRK-1:0] cmask_reg, cmask_next;
    logic            pend_reg, pend_next;
    logic            kept_reg, kept_next;
    logic            dropped_reg, dropped_next;
    logic            dropping_reg, dropping_next;
    logic            changed_reg, changed_next;
    logic [CW-1:0]   held_reg [HD];
    logic [CW-1:0]   held_next [HD];

    // Command fields.
    logic            e_sep_en, e_sep_amp, e_tail_en;
    logic [3:0]      e_hold_n;
    logic [CW-1:0]   e_tail;
    logic [HD*CW-1:0] e_hold;

    logic            is_delim, eu_first, eu, fk, exact, put_c, cq;
    logic            kc_keep, kc_drop, prefix_hit, do_keep, do_drop;
    logic [NTRK-1:0] nm;
    logic [CW-1:0]   fc;
    logic [3:0]      np;

    assign accept = push && !cmd_full;

    assign is_delim = (in_char == CW'(usp_pkg::CH_SPACE)) || (in_char == CW'(usp_pkg::CH_TAB))
                   || (in_char == CW'(usp_pkg::CH_CR))    || (in_char == CW'(usp_pkg::CH_LF))
                   || (in_char == CW'(usp_pkg::CH_RPAR))  || (in_char == CW'(usp_pkg::CH_RBRK))
                   || (in_char == CW'(usp_pkg::CH_GT))    || (in_char == CW'(usp_pkg::CH_DQUOT))
                   || (in_char == CW'(usp_pkg::CH_SQUOT));

    assign fc = (in_char >= C_UC_A && in_char <= C_UC_Z) ? in_char + CW'(32) : in_char;

    always_comb
    begin
        mode_next     = mode_reg;
        spos_next     = spos_reg;
        hcnt_next     = hcnt_reg;
        cmask_next    = cmask_reg;
        pend_next     = pend_reg;
        kept_next     = kept_reg;
        dropped_next  = dropped_reg;
        dropping_next = dropping_reg;
        changed_next  = changed_reg;
        held_next     = held_reg;
        e_sep_en      = 1'b0;
        e_sep_amp     = 1'b0;
        e_tail_en     = 1'b0;
        e_tail        = '0;
        e_hold_n      = 4'd0;
        e_hold        = '0;
        fk            = 1'b0;
        exact         = 1'b0;
        put_c         = 1'b0;
        cq            = 1'b0;
        kc_keep       = 1'b0;
        kc_drop       = 1'b0;
        prefix_hit    = 1'b0;
        nm            = '0;
        np            = 4'd0;

        eu_first = char_present && (mode_reg != usp_pkg::MODE_PLAIN) && is_delim;

        // Work that the character itself does, before any key decision.
        if (char_present && !eu_first)
        begin
            unique case (mode_reg)
                usp_pkg::MODE_PLAIN:
                begin
                    put_c = 1'b1;
                    if (spos_reg < 4'd4 && ((spos_reg == 4'd0 && in_char == C_H) ||
                        (spos_reg == 4'd1 && in_char == C_T) ||
                        (spos_reg == 4'd2 && in_char == C_T) ||
                        (spos_reg == 4'd3 && in_char == C_P)))
                        np = spos_reg + 4'd1;
                    else if (spos_reg == 4'd4 && in_char == C_S)
                        np = 4'd5;
                    else if ((spos_reg == 4'd4 || spos_reg == 4'd5) && in_char == C_COLON)
                        np = 4'd6;
                    else if (spos_reg == 4'd6 && in_char == C_SLASH)
                        np = 4'd7;
                    else if (spos_reg == 4'd7 && in_char == C_SLASH)
                        np = 4'd8;
                    else
                        np = (in_char == C_H) ? 4'd1 : 4'd0;
                    if (np == 4'd8)
                    begin
                        mode_next     = usp_pkg::MODE_PATH;
                        spos_next     = 4'd0;
                        kept_next     = 1'b0;
                        dropped_next  = 1'b0;
                        pend_next     = 1'b0;
                        hcnt_next     = 4'd0;
                        cmask_next    = '1;
                        dropping_next = 1'b0;
                    end
                    else
                    begin
                        spos_next = np;
                    end
                end
                usp_pkg::MODE_PATH:
                begin
                    if (in_char == C_QUEST)
                    begin
                        pend_next     = 1'b1;
                        hcnt_next     = 4'd0;
                        cmask_next    = '1;
                        dropping_next = 1'b0;
                        mode_next     = usp_pkg::MODE_KEY;
                    end
                    else
                    begin
                        put_c = 1'b1;
                    end
                end
                usp_pkg::MODE_KEY:
                begin
                    if (in_char == C_AMP || in_char == C_EQ)
                    begin
                        fk = 1'b1;
                    end
                    else if (in_char == C_HASH)
                    begin
                        fk = (hcnt_reg != 4'd0);
                    end
                    else
                    begin
                        // Narrow the tracker candidates by one more key character.
                        for (int i = 0; i < NTRK; i++)
                        begin
                            if (cmask_reg[i] && hcnt_reg < usp_pkg::trk_len(4'(i)) &&
                                hcnt_reg < 4'(HD) &&
                                fc == CW'(usp_pkg::trk_char(4'(i), hcnt_reg[2:0])))
                            begin
                                nm[i] = 1'b1;
                                if (usp_pkg::trk_len(4'(i)) == hcnt_reg + 4'd1 &&
                                    CW'(usp_pkg::trk_char(4'(i), hcnt_reg[2:0])) == C_UNDER)
                                    prefix_hit = 1'b1;
                            end
                        end
                        cmask_next = nm;
                        if (prefix_hit)
                        begin
                            kc_drop   = 1'b1;
                            mode_next = usp_pkg::MODE_VALUE;
                        end
                        else if (nm == '0 || hcnt_reg >= 4'(HD))
                        begin
                            kc_keep   = 1'b1;
                            put_c     = 1'b1;
                            mode_next = usp_pkg::MODE_VALUE;
                        end
                        else
                        begin
                            held_next[hcnt_reg[2:0]] = in_char;
                            hcnt_next = hcnt_reg + 4'd1;
                        end
                    end
                end
                usp_pkg::MODE_VALUE:
                begin
                    if (in_char == C_AMP)
                    begin
                        pend_next     = 1'b1;
                        hcnt_next     = 4'd0;
                        cmask_next    = '1;
                        dropping_next = 1'b0;
                        mode_next     = usp_pkg::MODE_KEY;
                    end
                    else if (in_char == C_HASH)
                    begin
                        cq        = 1'b1;
                        put_c     = 1'b1;
                        mode_next = usp_pkg::MODE_FRAG;
                    end
                    else
                    begin
                        put_c = !dropping_reg;
                    end
                end
                default:
                begin
                    put_c = 1'b1;
                end
            endcase
        end

        // The URL closes on a delimiter, or at text end while inside one.
        eu = eu_first || (text_end && mode_next != usp_pkg::MODE_PLAIN);
        if (eu && mode_next == usp_pkg::MODE_KEY && hcnt_next != 4'd0)
            fk = 1'b1;

        if (fk)
        begin
            for (int i = 0; i < NTRK; i++)
            begin
                if (cmask_next[i] && usp_pkg::trk_len(4'(i)) == hcnt_next)
                    exact = 1'b1;
            end
        end

        do_keep = kc_keep || (fk && !exact);
        do_drop = kc_drop || (fk && exact);

        if (do_keep)
        begin
            if (pend_next)
            begin
                e_sep_en  = 1'b1;
                e_sep_amp = kept_next;
            end
            e_hold_n = hcnt_next;
            for (int k = 0; k < HD; k++)
                e_hold[k*CW +: CW] = held_next[k];
            pend_next     = 1'b0;
            hcnt_next     = 4'd0;
            kept_next     = 1'b1;
            dropping_next = 1'b0;
        end
        if (do_drop)
        begin
            hcnt_next     = 4'd0;
            dropping_next = 1'b1;
            dropped_next  = 1'b1;
        end

        // What a key delimiter does once its key is decided.
        if (fk && char_present && mode_reg == usp_pkg::MODE_KEY && !eu_first)
        begin
            if (in_char == C_AMP)
            begin
                pend_next     = 1'b1;
                hcnt_next     = 4'd0;
                cmask_next    = '1;
                dropping_next = 1'b0;
            end
            else if (in_char == C_EQ)
            begin
                put_c     = !dropping_next;
                mode_next = usp_pkg::MODE_VALUE;
            end
        end
        if (char_present && mode_reg == usp_pkg::MODE_KEY && !eu_first && in_char == C_HASH)
        begin
            cq        = 1'b1;
            put_c     = 1'b1;
            mode_next = usp_pkg::MODE_FRAG;
        end

        // Closing the query: restore a separator only when nothing was removed.
        if (cq || eu)
        begin
            if (pend_next && !dropped_next)
            begin
                if (!e_sep_en && e_hold_n == 4'd0)
                begin
                    e_sep_en  = 1'b1;
                    e_sep_amp = kept_next;
                end
                else
                begin
                    e_tail_en = 1'b1;
                    e_tail    = kept_next ? C_AMP : C_QUEST;
                end
            end
            pend_next = 1'b0;
        end

        if (eu)
        begin
            if (dropped_next)
                changed_next = 1'b1;
            mode_next     = usp_pkg::MODE_PLAIN;
            spos_next     = 4'd0;
            kept_next     = 1'b0;
            dropped_next  = 1'b0;
            hcnt_next     = 4'd0;
            cmask_next    = '1;
            dropping_next = 1'b0;
        end

        // The delimiter that closes a URL is copied after everything the URL released.
        if (put_c || eu_first)
        begin
            e_tail_en = 1'b1;
            e_tail    = in_char;
        end

        cmd_data = {text_end, changed_next, e_sep_en, e_sep_amp, e_tail_en,
                    e_hold_n, e_tail, e_hold};
        cmd_push = accept && (text_end || e_sep_en || e_tail_en || e_hold_n != 4'd0);

        if (text_end)
        begin
            mode_next     = usp_pkg::MODE_PLAIN;
            spos_next     = 4'd0;
            hcnt_next     = 4'd0;
            cmask_next    = '1;
            pend_next     = 1'b0;
            kept_next     = 1'b0;
            dropped_next  = 1'b0;
            dropping_next = 1'b0;
            changed_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= usp_pkg::MODE_PLAIN;
            spos_reg     <= 4'd0;
            hcnt_reg     <= 4'd0;
            cmask_reg    <= '1;
            pend_reg     <= 1'b0;
            kept_reg     <= 1'b0;
            dropped_reg  <= 1'b0;
            dropping_reg <= 1'b0;
            changed_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            spos_reg     <= spos_next;
            hcnt_reg     <= hcnt_next;
            cmask_reg    <= cmask_next;
            pend_reg     <= pend_next;
            kept_reg     <= kept_next;
            dropped_reg  <= dropped_next;
            dropping_reg <= dropping_next;
            changed_reg  <= changed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

    a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hcnt_reg <= 4'(HD))
        else $error("key hold count above buffer depth");

    a_text_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text_end |=> mode_reg == usp_pkg::MODE_PLAIN && !changed_reg &&
                               hcnt_reg == 4'd0)
        else $error("state not cleared after text end");

    a_cmd_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command written into a full queue");

endmodule

// ===== rtl/usp_back.sv =====
// Back part: expands each command into output beats, one beat per cycle while the result queue has room.
module usp_back #(
    parameter int CHAR_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  logic [9*CHAR_BITS+8:0]   cmd_data,
    output logic                     cmd_pop,
    input  logic                     beat_full,
    output logic                     beat_push,
    output logic [CHAR_BITS-1:0]     beat_char,
    output usp_pkg::beat_flags_t     beat_flags
);

    localparam int CW = CHAR_BITS;
    localparam int HD = usp_pkg::HOLD_DEPTH;
    localparam int HB = HD * CW;

    logic [3:0]    k_reg, k_next;
    logic [CW-1:0] c_tail;
    logic [3:0]    c_hold_n, beat_total, j;
    logic          c_tail_en, c_sep_amp, c_sep_en, c_changed, c_fin, last, fire;

    assign c_tail    = cmd_data[HB +: CW];
    assign c_hold_n  = cmd_data[HB+CW +: 4];
    assign c_tail_en = cmd_data[HB+CW+4];
    assign c_sep_amp = cmd_data[HB+CW+5];
    assign c_sep_en  = cmd_data[HB+CW+6];
    assign c_changed = cmd_data[HB+CW+7];
    assign c_fin     = cmd_data[HB+CW+8];

    always_comb
    begin
        beat_total = {3'b000, c_sep_en} + c_hold_n + {3'b000, c_tail_en};
        if (beat_total == 4'd0)
            beat_total = 4'd1;
        j    = k_reg - {3'b000, c_sep_en};
        last = (k_reg == beat_total - 4'd1);
        beat_flags.char_valid = 1'b1;
        if (c_sep_en && k_reg == 4'd0)
            beat_char = c_sep_amp ? CW'(usp_pkg::CH_AMP) : CW'(usp_pkg::CH_QUEST);
        else if (j < c_hold_n)
            beat_char = cmd_data[j[2:0]*CW +: CW];
        else if (c_tail_en)
            beat_char = c_tail;
        else
        begin
            beat_char = '0;
            beat_flags.char_valid = 1'b0;
        end
        beat_flags.run_last     = last;
        beat_flags.text_done    = last && c_fin;
        beat_flags.text_changed = last && c_fin && c_changed;
        fire      = cmd_valid && !beat_full;
        beat_push = fire;
        cmd_pop   = fire && last;
        k_next    = k_reg;
        if (fire)
            k_next = last ? 4'd0 : k_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_reg <= 4'd0;
        else
            k_reg <= k_next;
    end

    a_beat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> k_reg < beat_total)
        else $error("beat counter ran past the command");

endmodule

// ===== rtl/url_tracker_param_stripper.sv =====
// Top level of the streaming URL tracker-parameter stripper.
//
//  Channel | Direction | Handshake       | Beat contents
//  --------+-----------+-----------------+-----------------------------------------------
//  input   | in        | push / full     | in_char, char_present, text_end
//  result  | out       | pop / empty     | out_char, char_valid, run_last, text_done,
//          |           |                 | text_changed
//
// One input beat is accepted per cycle whenever the command queue has room; the front
// scanner decides each character combinationally. Each beat yields zero to nine result
// beats, and the back expander delivers one result beat per cycle while the result queue
// has room, so a beat that releases held key characters occupies the back end until all
// its result beats are out. A four-entry command queue lets the scanner run ahead of the
// expander, and a two-entry result queue parts the expander from the consumer. Reset is
// asynchronous and active low; it clears all control state and both queues. Results pass
// through the command queue and then the result queue before they reach the consumer.
module url_tracker_param_stripper #(
    parameter int CHAR_BITS     = 16,
    parameter int TRACKER_COUNT = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [CHAR_BITS-1:0] in_char,
    input  logic                 char_present,
    input  logic                 text_end,
    input  logic                 pop,
    output logic                 empty,
    output logic [CHAR_BITS-1:0] out_char,
    output logic                 char_valid,
    output logic                 run_last,
    output logic                 text_done,
    output logic                 text_changed
);

    localparam int CMD_W  = 9 * CHAR_BITS + 9;
    localparam int BEAT_W = CHAR_BITS + 4;

    logic                 cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic [CMD_W-1:0]     cmd_wr, cmd_rd;
    logic                 beat_push, beat_full;
    logic [CHAR_BITS-1:0] beat_char;
    usp_pkg::beat_flags_t beat_flags, out_flags;
    logic [BEAT_W-1:0]    out_rd;

    // The front scanner classifies characters and records what each one releases.
    usp_front #(
        .CHAR_BITS     (CHAR_BITS),
        .TRACKER_COUNT (TRACKER_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .in_char      (in_char),
        .char_present (char_present),
        .text_end     (text_end),
        .cmd_full     (cmd_full),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_wr)
    );

    assign full = cmd_full;

    // Commands wait here so the scanner keeps taking input during long expansions.
    usp_fifo #(
        .WIDTH      (CMD_W),
        .DEPTH_LOG2 (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wr),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    // The back expander turns each command into separator, held and current characters.
    usp_back #(
        .CHAR_BITS (CHAR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (!cmd_empty),
        .cmd_data   (cmd_rd),
        .cmd_pop    (cmd_pop),
        .beat_full  (beat_full),
        .beat_push  (beat_push),
        .beat_char  (beat_char),
        .beat_flags (beat_flags)
    );

    // The result queue holds finished beats while the consumer stalls.
    usp_fifo #(
        .WIDTH      (BEAT_W),
        .DEPTH_LOG2 (1)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (beat_push),
        .wr_data ({beat_flags, beat_char}),
        .rd_en   (pop),
        .rd_data (out_rd),
        .full    (beat_full),
        .empty   (empty)
    );

    assign out_char     = out_rd[CHAR_BITS-1:0];
    assign out_flags    = usp_pkg::beat_flags_t'(out_rd[CHAR_BITS +: 4]);
    assign char_valid   = out_flags.char_valid;
    assign run_last     = out_flags.run_last;
    assign text_done    = out_flags.text_done;
    assign text_changed = out_flags.text_changed;

endmodule
